// ----- hdl/sse_pkg.sv -----
// ----------------------------------------------------------------------------
// sse_pkg: shared types, codes and microprogram of the subset-sum enumerator
// Holds the port field widths, the status and mode codes, the control word
// layout and the read-only microprogram that drives the datapath.
// ----------------------------------------------------------------------------
package sse_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int TARGET_W   = 20;
  localparam int MODE_W     = 2;
  localparam int ELEM_IN_W  = 16;
  localparam int STATUS_W   = 3;
  localparam int MASK_OUT_W = 16;

  // Defaults for the top-level parameters.
  localparam int MAX_ELEMENTS_DEF = 16;
  localparam int ELEMENT_BITS_DEF = 16;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIND  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED   = 3'd0,
    ST_REFUSED  = 3'd1,
    ST_FOUND    = 3'd2,
    ST_FINISHED = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  // Datapath operation of one microstep.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LOAD,
    OP_CLEAR,
    OP_PUSH_ROOT,
    OP_POP,
    OP_LATCH,
    OP_PUSH_INC,
    OP_PUSH_EXC,
    OP_EMIT
  } op_t;

  // Branch condition of one microstep.
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_FIRE,
    C_MODE_FIND,
    C_MODE_LOAD,
    C_MODE_CLEAR,
    C_FULL,
    C_STARTED,
    C_EMPTY,
    C_EXPAND,
    C_HIT,
    C_OUT_BUSY
  } cond_t;

  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  // Microprogram addresses.
  localparam upc_t U_IDLE     = 5'd0;
  localparam upc_t U_DISP     = 5'd1;
  localparam upc_t U_DISP2    = 5'd2;
  localparam upc_t U_DISP3    = 5'd3;
  localparam upc_t U_LOAD     = 5'd4;
  localparam upc_t U_CLEAR    = 5'd5;
  localparam upc_t U_FSTART   = 5'd6;
  localparam upc_t U_ROOT     = 5'd7;
  localparam upc_t U_CHECK    = 5'd8;
  localparam upc_t U_POP      = 5'd9;
  localparam upc_t U_LATCH    = 5'd10;
  localparam upc_t U_TEST     = 5'd11;
  localparam upc_t U_PINC     = 5'd12;
  localparam upc_t U_PEXC     = 5'd13;
  localparam upc_t U_HIT      = 5'd14;
  localparam upc_t U_EM_FOUND = 5'd15;
  localparam upc_t U_EM_FIN   = 5'd16;
  localparam upc_t U_EM_LOAD  = 5'd17;
  localparam upc_t U_EM_REF   = 5'd18;
  localparam upc_t U_EM_CLR   = 5'd19;

  // One control word: operation, branch condition, taken and not-taken
  // targets, and the status that an emit step reports.
  typedef struct packed {
    op_t     op;
    cond_t   cond;
    upc_t    jt;
    upc_t    jf;
    status_t status;
  } ctrl_t;

  // Condition flags returned by the datapath.
  typedef struct packed {
    logic in_fire;
    logic mode_find;
    logic mode_load;
    logic mode_clear;
    logic full;
    logic started;
    logic empty;
    logic expand;
    logic hit;
    logic out_busy;
  } flags_t;

  function automatic ctrl_t ucode_rom(input upc_t pc);
    ctrl_t w;
    case (pc)
      U_IDLE:     w = '{OP_ACCEPT,    C_IN_FIRE,    U_DISP,     U_IDLE,    ST_FINISHED};
      U_DISP:     w = '{OP_NOP,       C_MODE_FIND,  U_FSTART,   U_DISP2,   ST_FINISHED};
      U_DISP2:    w = '{OP_NOP,       C_MODE_LOAD,  U_LOAD,     U_DISP3,   ST_FINISHED};
      U_DISP3:    w = '{OP_NOP,       C_MODE_CLEAR, U_CLEAR,    U_EM_FIN,  ST_FINISHED};
      U_LOAD:     w = '{OP_LOAD,      C_FULL,       U_EM_REF,   U_EM_LOAD, ST_FINISHED};
      U_CLEAR:    w = '{OP_CLEAR,     C_ALWAYS,     U_EM_CLR,   U_EM_CLR,  ST_FINISHED};
      U_FSTART:   w = '{OP_NOP,       C_STARTED,    U_CHECK,    U_ROOT,    ST_FINISHED};
      U_ROOT:     w = '{OP_PUSH_ROOT, C_ALWAYS,     U_CHECK,    U_CHECK,   ST_FINISHED};
      U_CHECK:    w = '{OP_NOP,       C_EMPTY,      U_EM_FIN,   U_POP,     ST_FINISHED};
      U_POP:      w = '{OP_POP,       C_ALWAYS,     U_LATCH,    U_LATCH,   ST_FINISHED};
      U_LATCH:    w = '{OP_LATCH,     C_ALWAYS,     U_TEST,     U_TEST,    ST_FINISHED};
      U_TEST:     w = '{OP_NOP,       C_EXPAND,     U_PINC,     U_HIT,     ST_FINISHED};
      U_PINC:     w = '{OP_PUSH_INC,  C_ALWAYS,     U_PEXC,     U_PEXC,    ST_FINISHED};
      U_PEXC:     w = '{OP_PUSH_EXC,  C_ALWAYS,     U_HIT,      U_HIT,     ST_FINISHED};
      U_HIT:      w = '{OP_NOP,       C_HIT,        U_EM_FOUND, U_CHECK,   ST_FINISHED};
      U_EM_FOUND: w = '{OP_EMIT,      C_OUT_BUSY,   U_EM_FOUND, U_IDLE,    ST_FOUND};
      U_EM_FIN:   w = '{OP_EMIT,      C_OUT_BUSY,   U_EM_FIN,   U_IDLE,    ST_FINISHED};
      U_EM_LOAD:  w = '{OP_EMIT,      C_OUT_BUSY,   U_EM_LOAD,  U_IDLE,    ST_LOADED};
      U_EM_REF:   w = '{OP_EMIT,      C_OUT_BUSY,   U_EM_REF,   U_IDLE,    ST_REFUSED};
      U_EM_CLR:   w = '{OP_EMIT,      C_OUT_BUSY,   U_EM_CLR,   U_IDLE,    ST_CLEARED};
      default:    w = '{OP_NOP,       C_ALWAYS,     U_IDLE,     U_IDLE,    ST_FINISHED};
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/sse_sequencer.sv -----
// ----------------------------------------------------------------------------
// sse_sequencer: microprogram counter of the subset-sum enumerator
// Steps through the microprogram, one control word per cycle, and takes a
// conditional branch on the flags from the datapath.
// ----------------------------------------------------------------------------
module sse_sequencer
  import sse_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  upc_t  pc_r;
  upc_t  pc_nxt;
  ctrl_t word;
  logic  taken;

  assign word = ucode_rom(pc_r);
  assign ctrl = word;

  always_comb begin
    case (word.cond)
      C_ALWAYS:     taken = 1'b1;
      C_IN_FIRE:    taken = flags.in_fire;
      C_MODE_FIND:  taken = flags.mode_find;
      C_MODE_LOAD:  taken = flags.mode_load;
      C_MODE_CLEAR: taken = flags.mode_clear;
      C_FULL:       taken = flags.full;
      C_STARTED:    taken = flags.started;
      C_EMPTY:      taken = flags.empty;
      C_EXPAND:     taken = flags.expand;
      C_HIT:        taken = flags.hit;
      C_OUT_BUSY:   taken = flags.out_busy;
      default:      taken = 1'b1;
    endcase
    pc_nxt = taken ? word.jt : word.jf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= U_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- hdl/sse_datapath.sv -----
// ----------------------------------------------------------------------------
// sse_datapath: element store, search stack and result register
// Carries out the operation named by each control word: loading elements,
// pushing and popping search states, and handing results to the output.
// ----------------------------------------------------------------------------
module sse_datapath
  import sse_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_t                 ctrl,
  output flags_t                flags,
  input  logic                  cfg_wr_en,
  input  logic [TARGET_W-1:0]   cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [ELEM_IN_W-1:0]  in_tdata,
  input  logic [MODE_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [MASK_OUT_W-1:0] out_tdata,
  output logic [STATUS_W-1:0]   out_tuser
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS + 1);
  localparam int SA_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int STK_N = MAX_ELEMENTS + 1;
  localparam int SK_W  = $clog2(STK_N);
  localparam int DEP_W = $clog2(STK_N + 1);
  localparam int SUM_W = ((ELEMENT_BITS > TARGET_W) ? ELEMENT_BITS : TARGET_W) + 1;
  localparam int ENT_W = IDX_W + SUM_W + MAX_ELEMENTS;

  // Control state.
  logic [TARGET_W-1:0]    target_r;
  logic [IDX_W-1:0]       cnt_r, cnt_nxt;
  logic [DEP_W-1:0]       depth_r, depth_nxt;
  logic                   started_r, started_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Payload.
  logic [MODE_W-1:0]       mode_r;
  logic [ELEMENT_BITS-1:0] new_elem_r;
  logic [IDX_W-1:0]        cur_idx_r;
  logic [SUM_W-1:0]        cur_sum_r;
  logic [MAX_ELEMENTS-1:0] cur_mask_r;
  logic                    hit_r;
  logic                    expand_r;
  status_t                 out_status_r;
  logic [MASK_OUT_W-1:0]   out_mask_r;

  // Memories.
  logic [ELEMENT_BITS-1:0] store_mem [MAX_ELEMENTS];
  logic [ELEMENT_BITS-1:0] elem_q;
  logic [ENT_W-1:0]        stk_mem [STK_N];
  logic [ENT_W-1:0]        stk_q;

  logic                    in_fire;
  logic                    out_busy;
  logic                    emit_go;
  logic                    full;
  logic                    stk_full;
  logic                    store_we;
  logic                    stk_we;
  logic                    stk_re;
  logic [SK_W-1:0]         stk_waddr;
  logic [SK_W-1:0]         stk_raddr;
  logic [ENT_W-1:0]        stk_wdata;
  logic [DEP_W-1:0]        depth_m1;
  logic [IDX_W-1:0]        stk_idx;
  logic [SUM_W-1:0]        stk_sum;
  logic [MAX_ELEMENTS-1:0] stk_mask;
  logic [SUM_W-1:0]        target_ext;
  logic [IDX_W-1:0]        next_idx;
  logic [SUM_W-1:0]        inc_sum;
  logic [MAX_ELEMENTS-1:0] bit_sel;
  logic [31:0]             in_elem_ext;
  logic [MAX_ELEMENTS+MASK_OUT_W-1:0] mask_ext;

  assign in_tready   = (ctrl.op == OP_ACCEPT);
  assign in_fire     = in_tvalid && in_tready;
  assign out_busy    = out_valid_r && !out_tready;
  assign emit_go     = (ctrl.op == OP_EMIT) && !out_busy;
  assign full        = (cnt_r == IDX_W'(MAX_ELEMENTS));
  assign stk_full    = (depth_r == DEP_W'(STK_N));
  assign in_elem_ext = {{(32 - ELEM_IN_W){1'b0}}, in_tdata};

  assign depth_m1   = depth_r - 1'b1;
  assign stk_raddr  = depth_m1[SK_W-1:0];
  assign stk_idx    = stk_q[ENT_W-1 -: IDX_W];
  assign stk_sum    = stk_q[MAX_ELEMENTS +: SUM_W];
  assign stk_mask   = stk_q[MAX_ELEMENTS-1:0];
  assign target_ext = SUM_W'(target_r);

  assign next_idx = cur_idx_r + 1'b1;
  assign inc_sum  = cur_sum_r + SUM_W'(elem_q);
  assign bit_sel  = MAX_ELEMENTS'(1) << cur_idx_r;
  assign mask_ext = {{MASK_OUT_W{1'b0}}, cur_mask_r};

  always_comb begin
    cnt_nxt       = cnt_r;
    depth_nxt     = depth_r;
    started_nxt   = started_r;
    store_we      = 1'b0;
    stk_we        = 1'b0;
    stk_re        = 1'b0;
    stk_waddr     = depth_r[SK_W-1:0];
    stk_wdata     = {next_idx, cur_sum_r, cur_mask_r};
    out_valid_nxt = out_valid_r && !out_tready;
    case (ctrl.op)
      OP_LOAD: begin
        started_nxt = 1'b0;
        depth_nxt   = '0;
        if (!full) begin
          store_we = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      OP_CLEAR: begin
        cnt_nxt     = '0;
        depth_nxt   = '0;
        started_nxt = 1'b0;
      end
      OP_PUSH_ROOT: begin
        stk_we      = 1'b1;
        stk_waddr   = '0;
        stk_wdata   = '0;
        depth_nxt   = DEP_W'(1);
        started_nxt = 1'b1;
      end
      OP_POP: begin
        stk_re    = 1'b1;
        depth_nxt = depth_m1;
      end
      OP_PUSH_INC: begin
        if (!stk_full) begin
          stk_we    = 1'b1;
          stk_wdata = {next_idx, inc_sum, cur_mask_r | bit_sel};
          depth_nxt = depth_r + 1'b1;
        end
      end
      OP_PUSH_EXC: begin
        if (!stk_full) begin
          stk_we    = 1'b1;
          depth_nxt = depth_r + 1'b1;
        end
      end
      OP_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      cnt_r       <= '0;
      depth_r     <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
      cnt_r       <= cnt_nxt;
      depth_r     <= depth_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r     <= in_tuser;
      new_elem_r <= in_elem_ext[ELEMENT_BITS-1:0];
    end
    if (ctrl.op == OP_LATCH) begin
      cur_idx_r  <= stk_idx;
      cur_sum_r  <= stk_sum;
      cur_mask_r <= stk_mask;
      hit_r      <= (stk_sum == target_ext);
      expand_r   <= (stk_idx < cnt_r) && (stk_sum <= target_ext);
    end
    if (emit_go) begin
      out_status_r <= ctrl.status;
      out_mask_r   <= (ctrl.status == ST_FOUND) ? mask_ext[MASK_OUT_W-1:0] : '0;
    end
  end

  // Element store: written at the fill count, read at the popped index.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[cnt_r[SA_W-1:0]] <= new_elem_r;
    end
    elem_q <= store_mem[stk_idx[SA_W-1:0]];
  end

  // Search stack: one push or one pop per cycle.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_q <= stk_mem[stk_raddr];
    end
  end

  assign flags = '{
    in_fire:    in_fire,
    mode_find:  (mode_r == MODE_FIND),
    mode_load:  (mode_r == MODE_LOAD),
    mode_clear: (mode_r == MODE_CLEAR),
    full:       full,
    started:    started_r,
    empty:      (depth_r == '0),
    expand:     expand_r,
    hit:        hit_r,
    out_busy:   out_busy
  };

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mask_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (DEP_W + 1)'(depth_r) <= (DEP_W + 1)'(cnt_r) + 1'b1)
    else $error("search stack deeper than element count plus one");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= IDX_W'(MAX_ELEMENTS))
    else $error("element count beyond store size");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_PUSH_INC || ctrl.op == OP_PUSH_EXC) |-> !stk_full)
    else $error("push onto a full search stack");

  a_mask_found_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_FOUND) |-> (out_mask_r == '0))
    else $error("nonzero mask on a result that is not a found subset");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_POP) |-> (depth_r != '0))
    else $error("pop from an empty search stack");
`endif

endmodule

// ----- hdl/subset_sum_enumerator_core.sv -----
// ----------------------------------------------------------------------------
// subset_sum_enumerator_core: microcoded subset-sum enumerator
// Loads up to MAX_ELEMENTS values and returns, one per request, every subset
// whose sum equals the programmed target, found by depth-first backtracking.
// ----------------------------------------------------------------------------
// A load request (mode 0) appends one element and answers loaded, or refused
// when the store is full; it also restarts the search. A clear request
// (mode 2) empties the store and answers cleared. A find request (mode 1)
// answers with the next matching subset as a bit mask (bit i for element i),
// or with finished once every subset has been visited; finished then repeats
// until the next load or clear. Mode 3 answers finished and changes nothing.
// A matching mask is reported again from each state that only leaves out
// further elements, by design. The search keeps its position between find
// requests on an internal stack of MAX_ELEMENTS+1 entries, so a request
// resumes where the last one stopped. All work is done by a small
// microprogram stepping a single datapath, one control word per cycle.
// Load, clear and unused requests pass through the dispatch steps to an
// emit step. A find request runs its setup steps and then, for each search
// state visited, the steps check, pop, read, test and match check, plus one
// push step per child when the state is expanded into its two children,
// which go onto the stack one push per cycle through its single write port.
// The total time is therefore data dependent. A new request is accepted
// while the previous result is still waiting on the output; a result waits
// in the sequencer only if the output register is still occupied. The user
// must write the target through cfg_wr_en/cfg_wr_data only while the block
// is idle; the block itself does not enforce this. The target is used from
// the next state that is examined. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module subset_sum_enumerator_core
  import sse_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration: target_sum.
  input  logic                  cfg_wr_en,
  input  logic [TARGET_W-1:0]   cfg_wr_data,
  // Request channel.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [ELEM_IN_W-1:0]  in_tdata,   // [15:0] element_value
  input  logic [MODE_W-1:0]     in_tuser,   // [1:0] mode
  // Result channel.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [MASK_OUT_W-1:0] out_tdata,  // [15:0] subset_mask
  output logic [STATUS_W-1:0]   out_tuser   // [2:0] status
);

  // Control word from the microprogram, condition flags back to it.
  ctrl_t  ctrl;
  flags_t flags;

  sse_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // Element store, search stack, target register and result register.
  sse_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .flags       (flags),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule
